@@ rtl/ccfp_pkg.sv @@
// Shared types and constants for the character-cell framebuffer plotter.
// No dependencies; used by every module of the block.
package ccfp_pkg;

    // Command codes of an input word.
    localparam logic [2:0] CMD_POINT  = 3'd0;
    localparam logic [2:0] CMD_LINE   = 3'd1;
    localparam logic [2:0] CMD_CLEAR  = 3'd2;
    localparam logic [2:0] CMD_REDRAW = 3'd3;
    localparam logic [2:0] CMD_RENDER = 3'd4;

    // Status codes of a result word.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_COLLISION = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_WIDTH    = 3'd0;
    localparam logic [2:0] REG_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_BG_GLYPH = 3'd2;
    localparam logic [2:0] REG_BG_COLOR = 3'd3;
    localparam logic [2:0] REG_DEF_COLOR = 3'd4;

    // Reset values.
    localparam logic [6:0]  RST_WIDTH    = 7'd64;
    localparam logic [6:0]  RST_HEIGHT   = 7'd64;
    localparam logic [7:0]  RST_BG_GLYPH = 8'd32;
    localparam logic [15:0] RST_BG_COLOR = 16'd0;

    // Line interpolation divider sizes.
    localparam int NUM_W = 18;
    localparam int DEN_W = 9;
    localparam int CNT_W = 5;

    typedef struct packed {
        logic        changed;
        logic [7:0]  glyph;
        logic [15:0] color;
    } t_cell;

endpackage

@@ rtl/char_cell_framebuffer_plotter_unit.sv @@
// Character-cell framebuffer with changed-cell map; depends on ccfp_pkg and ccfp_div.
// Every cell access is a read of the cell memory in S_CELL and a write back in S_WR. A
// point visits one cell; a straight line visits its cells in turn; a diagonal line runs
// the divider once per column (18 steps per column); a render walks width cells of one
// row; a clear or force redraw walks all width*height cells.
// After reset the block sweeps the whole memory once with o_stall high; configuration
// writes are taken during that sweep.
module char_cell_framebuffer_plotter_unit
    import ccfp_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic signed [7:0] i_x_start,
    input  logic signed [7:0] i_y_start,
    input  logic signed [7:0] i_x_end,
    input  logic signed [7:0] i_y_end,
    input  logic [7:0]  i_glyph,
    input  logic        i_overwrite,
    input  logic        i_use_default_color,
    input  logic [15:0] i_color,
    input  logic        i_force_all,
    // Output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_cell_valid,
    output logic [5:0]  o_cell_x,
    output logic [5:0]  o_cell_y,
    output logic [7:0]  o_cell_glyph,
    output logic [15:0] o_cell_color,
    output logic        o_last,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [6:0] MAXW = 7'(MAX_WIDTH);
    localparam logic [8:0] MAXH = 9'(MAX_HEIGHT);

    // Sequencer states.
    localparam logic [2:0] S_INIT     = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_PREP     = 3'd2;
    localparam logic [2:0] S_DIV_GO   = 3'd3;
    localparam logic [2:0] S_DIV_WAIT = 3'd4;
    localparam logic [2:0] S_CELL     = 3'd5;
    localparam logic [2:0] S_WR       = 3'd6;
    localparam logic [2:0] S_FIN      = 3'd7;

    // Kinds of line walk.
    localparam logic [1:0] L_VERT = 2'd0;
    localparam logic [1:0] L_HORZ = 2'd1;
    localparam logic [1:0] L_DIAG = 2'd2;

    // Configuration registers.
    logic [6:0]  r_width, r_height;
    logic [7:0]  r_bg_glyph;
    logic [15:0] r_bg_color, r_def_color;

    logic        cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= RST_WIDTH;
            r_height    <= RST_HEIGHT;
            r_bg_glyph  <= RST_BG_GLYPH;
            r_bg_color  <= RST_BG_COLOR;
            r_def_color <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_WIDTH:     r_width     <= pwdata[6:0];
                REG_HEIGHT:    r_height    <= pwdata[6:0];
                REG_BG_GLYPH:  r_bg_glyph  <= pwdata[7:0];
                REG_BG_COLOR:  r_bg_color  <= pwdata[15:0];
                REG_DEF_COLOR: r_def_color <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_WIDTH:     prdata = {25'd0, r_width};
            REG_HEIGHT:    prdata = {25'd0, r_height};
            REG_BG_GLYPH:  prdata = {24'd0, r_bg_glyph};
            REG_BG_COLOR:  prdata = {16'd0, r_bg_color};
            REG_DEF_COLOR: prdata = {16'd0, r_def_color};
            default:       prdata = '0;
        endcase
    end

    // The size registers clamp to 1..maximum.
    logic [6:0] w_eff;
    logic [8:0] h_eff;
    always_comb begin
        if (r_width == 7'd0) w_eff = 7'd1;
        else if (r_width > MAXW) w_eff = MAXW;
        else w_eff = r_width;
        if (r_height == 7'd0) h_eff = 9'd1;
        else if ({2'b0, r_height} > MAXH) h_eff = MAXH;
        else h_eff = {2'b0, r_height};
    end

    // Cell memory: glyph, color and changed bit packed in one word.
    t_cell   r_mem [DEPTH];
    t_cell   r_rdata;
    logic    mem_we, mem_re;
    logic [AW-1:0] mem_waddr;
    t_cell   mem_wdata;

    // Sequencer state.
    logic [2:0]  r_state, n_state;
    logic [2:0]  r_cmd, n_cmd;
    logic [1:0]  r_lmode, n_lmode;
    logic signed [9:0] r_cx, n_cx, r_cy, n_cy, r_xe, n_xe, r_ye, n_ye;
    logic [7:0]  r_dx, n_dx, r_i, n_i;
    logic signed [8:0] r_dy, n_dy;
    logic signed [7:0] r_y1, n_y1;
    logic signed [18:0] r_num, n_num;
    logic [7:0]  r_glyph, n_glyph;
    logic        r_ovr, n_ovr, r_force, n_force;
    logic [15:0] r_col, n_col;
    logic [1:0]  r_status, n_status;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_init, n_init;

    // A changed cell of the current render that waits until the next one
    // shows whether it is the last.
    logic        r_pend, n_pend;
    logic [5:0]  r_pend_x, n_pend_x;
    logic [7:0]  r_pend_glyph, n_pend_glyph;
    logic [15:0] r_pend_color, n_pend_color;

    // Output register.
    logic        r_ov, n_ov;
    logic [1:0]  r_ost, n_ost;
    logic        r_ocv, n_ocv;
    logic [5:0]  r_ox, n_ox, r_oy, n_oy;
    logic [7:0]  r_og, n_og;
    logic [15:0] r_oc, n_oc;
    logic        r_olast, n_olast;

    // Divider for the diagonal row.
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_quo, div_mag;
    logic              num_neg;
    logic [9:0]        q10;

    assign num_neg = r_num[18];
    assign div_mag = num_neg ? NUM_W'(-r_num) : NUM_W'(r_num);
    assign q10     = div_quo[9:0];

    ccfp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_mag),
        .i_den   ({r_dx, 1'b0}),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Input decode helpers.
    logic signed [9:0] in_x1, in_y1, in_x2, in_y2;
    logic              swap;
    logic signed [16:0] prod;
    logic              out_free;
    logic              cur_in;
    logic              adv_done;
    logic              occupied;

    assign in_x1 = 10'(i_x_start);
    assign in_y1 = 10'(i_y_start);
    assign in_x2 = 10'(i_x_end);
    assign in_y2 = 10'(i_y_end);
    assign swap  = i_x_start > i_x_end;
    assign prod  = r_y1 * $signed({1'b0, r_dx});
    assign out_free = !r_ov || !i_stall;
    assign cur_in = (r_cx >= 0) && (r_cx < $signed({3'b0, w_eff}))
                 && (r_cy >= 0) && (r_cy < $signed({1'b0, h_eff}));
    assign occupied = r_rdata.glyph != r_bg_glyph;

    // End of walk for the current command at the current cell.
    always_comb begin
        case (r_cmd)
            CMD_LINE: begin
                case (r_lmode)
                    L_VERT:  adv_done = r_cy == r_ye;
                    L_HORZ:  adv_done = r_cx == r_xe;
                    default: adv_done = r_i == r_dx;
                endcase
            end
            CMD_CLEAR, CMD_REDRAW:
                adv_done = (r_cx[6:0] == w_eff - 7'd1) && (r_cy[8:0] == h_eff - 9'd1);
            CMD_RENDER: adv_done = r_cx[6:0] == w_eff - 7'd1;
            default:    adv_done = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;   n_cmd = r_cmd;     n_lmode = r_lmode;
        n_cx = r_cx;         n_cy = r_cy;       n_xe = r_xe;      n_ye = r_ye;
        n_dx = r_dx;         n_i = r_i;         n_dy = r_dy;      n_y1 = r_y1;
        n_num = r_num;       n_glyph = r_glyph; n_ovr = r_ovr;    n_force = r_force;
        n_col = r_col;       n_status = r_status; n_addr = r_addr; n_init = r_init;
        n_pend = r_pend;     n_pend_x = r_pend_x;
        n_pend_glyph = r_pend_glyph; n_pend_color = r_pend_color;
        n_ov = r_ov;         n_ost = r_ost;     n_ocv = r_ocv;
        n_ox = r_ox;         n_oy = r_oy;       n_og = r_og;      n_oc = r_oc;
        n_olast = r_olast;
        mem_we = 1'b0;       mem_re = 1'b0;
        mem_waddr = r_addr;  mem_wdata = r_rdata;
        div_start = 1'b0;

        if (r_ov && !i_stall) n_ov = 1'b0;

        case (r_state)
            S_INIT: begin
                // Sweep every entry to its reset contents.
                mem_we    = 1'b1;
                mem_waddr = r_init;
                mem_wdata = '{changed: 1'b1, glyph: RST_BG_GLYPH, color: RST_BG_COLOR};
                n_init    = r_init + AW'(1);
                if (r_init == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd    = i_cmd;
                    n_glyph  = i_glyph;
                    n_ovr    = i_overwrite;
                    n_force  = i_force_all;
                    n_col    = i_use_default_color ? r_def_color : i_color;
                    n_status = ST_OK;
                    n_pend   = 1'b0;
                    n_cx     = in_x1;
                    n_cy     = in_y1;
                    n_xe     = in_x2;
                    n_ye     = in_y2;
                    n_i      = '0;
                    case (i_cmd)
                        CMD_POINT: n_state = S_CELL;
                        CMD_LINE: begin
                            if (i_x_start == i_x_end) begin
                                n_lmode = L_VERT;
                                n_state = (i_y_start > i_y_end) ? S_FIN : S_CELL;
                            end else if (i_y_start == i_y_end) begin
                                n_lmode = L_HORZ;
                                n_state = swap ? S_FIN : S_CELL;
                            end else begin
                                n_lmode = L_DIAG;
                                n_cx    = swap ? in_x2 : in_x1;
                                n_y1    = swap ? i_y_end : i_y_start;
                                n_dx    = swap ? 8'(i_x_start - i_x_end)
                                               : 8'(i_x_end - i_x_start);
                                n_dy    = swap ? 9'(in_y1 - in_y2) : 9'(in_y2 - in_y1);
                                n_state = S_PREP;
                            end
                        end
                        CMD_CLEAR, CMD_REDRAW: begin
                            n_cx    = '0;
                            n_cy    = '0;
                            n_state = S_CELL;
                        end
                        CMD_RENDER: begin
                            n_cx = '0;
                            if (in_y1 < 0 || in_y1 >= $signed({1'b0, h_eff})) begin
                                n_status = ST_RANGE;
                                n_state  = S_FIN;
                            end else begin
                                n_state = S_CELL;
                            end
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_PREP: begin
                // Numerator of the first column: 2*y1*dx + dx.
                n_num   = {prod[16], prod, 1'b0} + {11'd0, r_dx};
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    // Quotient truncated toward zero.
                    n_cy    = num_neg ? $signed(-q10) : $signed(q10);
                    n_state = S_CELL;
                end
            end
            S_CELL: begin
                if (cur_in) begin
                    mem_re  = 1'b1;
                    n_addr  = AW'(AW'(r_cy[8:0]) * AW'(MAX_WIDTH) + AW'(r_cx[6:0]));
                    n_state = S_WR;
                end else if (r_cmd == CMD_POINT) begin
                    n_status = ST_RANGE;
                    n_state  = S_FIN;
                end else if (adv_done) begin
                    n_state = S_FIN;
                end else begin
                    // Out-of-range line points are skipped without a word.
                    case (r_lmode)
                        L_VERT: n_cy = r_cy + 10'sd1;
                        L_HORZ: n_cx = r_cx + 10'sd1;
                        default: begin
                            n_cx    = r_cx + 10'sd1;
                            n_i     = r_i + 8'd1;
                            n_num   = r_num + {{9{r_dy[8]}}, r_dy, 1'b0};
                            n_state = S_DIV_GO;
                        end
                    endcase
                end
            end
            S_WR: begin
                logic go;
                go = 1'b1;
                case (r_cmd)
                    CMD_POINT, CMD_LINE: begin
                        if (occupied && !r_ovr) begin
                            if (r_cmd == CMD_POINT) n_status = ST_COLLISION;
                        end else begin
                            mem_we    = 1'b1;
                            mem_wdata = '{changed: 1'b1, glyph: r_glyph, color: r_col};
                        end
                    end
                    CMD_CLEAR: begin
                        mem_we = 1'b1;
                        if (!r_force && !occupied && r_rdata.color == r_bg_color) begin
                            mem_wdata = '{changed: 1'b0, glyph: r_bg_glyph,
                                          color: r_bg_color};
                        end else begin
                            mem_wdata = '{changed: 1'b1, glyph: r_bg_glyph,
                                          color: r_bg_color};
                        end
                    end
                    CMD_REDRAW: begin
                        mem_we    = 1'b1;
                        mem_wdata = '{changed: 1'b1, glyph: r_rdata.glyph,
                                      color: r_rdata.color};
                    end
                    default: begin
                        if (r_rdata.changed) begin
                            if (r_pend && !out_free) begin
                                go = 1'b0;
                            end else begin
                                if (r_pend) begin
                                    n_ov = 1'b1;   n_ost = ST_OK;  n_ocv = 1'b1;
                                    n_ox = r_pend_x;  n_oy = r_cy[5:0];
                                    n_og = r_pend_glyph;  n_oc = r_pend_color;
                                    n_olast = 1'b0;
                                end
                                mem_we       = 1'b1;
                                mem_wdata    = '{changed: 1'b0, glyph: r_rdata.glyph,
                                                 color: r_rdata.color};
                                n_pend       = 1'b1;
                                n_pend_x     = r_cx[5:0];
                                n_pend_glyph = r_rdata.glyph;
                                n_pend_color = r_rdata.color;
                            end
                        end
                    end
                endcase
                if (go) begin
                    if (adv_done) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_CELL;
                        case (r_cmd)
                            CMD_LINE: begin
                                case (r_lmode)
                                    L_VERT: n_cy = r_cy + 10'sd1;
                                    L_HORZ: n_cx = r_cx + 10'sd1;
                                    default: begin
                                        n_cx    = r_cx + 10'sd1;
                                        n_i     = r_i + 8'd1;
                                        n_num   = r_num + {{9{r_dy[8]}}, r_dy, 1'b0};
                                        n_state = S_DIV_GO;
                                    end
                                endcase
                            end
                            CMD_CLEAR, CMD_REDRAW: begin
                                if (r_cx[6:0] == w_eff - 7'd1) begin
                                    n_cx = '0;
                                    n_cy = r_cy + 10'sd1;
                                end else begin
                                    n_cx = r_cx + 10'sd1;
                                end
                            end
                            default: n_cx = r_cx + 10'sd1;
                        endcase
                    end
                end
            end
            S_FIN: begin
                // The closing word: the held changed cell, or a plain status.
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_olast = 1'b1;
                    if (r_pend) begin
                        n_ost = ST_OK;  n_ocv = 1'b1;
                        n_ox = r_pend_x;  n_oy = r_cy[5:0];
                        n_og = r_pend_glyph;  n_oc = r_pend_color;
                    end else begin
                        n_ost = r_status;  n_ocv = 1'b0;
                        n_ox = '0;  n_oy = '0;  n_og = '0;  n_oc = '0;
                    end
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_init  <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
        r_cmd <= n_cmd;  r_lmode <= n_lmode;
        r_cx <= n_cx;    r_cy <= n_cy;    r_xe <= n_xe;    r_ye <= n_ye;
        r_dx <= n_dx;    r_i <= n_i;      r_dy <= n_dy;    r_y1 <= n_y1;
        r_num <= n_num;  r_glyph <= n_glyph;  r_ovr <= n_ovr;  r_force <= n_force;
        r_col <= n_col;  r_status <= n_status;  r_addr <= n_addr;
        r_pend_x <= n_pend_x;  r_pend_glyph <= n_pend_glyph;
        r_pend_color <= n_pend_color;
        r_ost <= n_ost;  r_ocv <= n_ocv;  r_ox <= n_ox;  r_oy <= n_oy;
        r_og <= n_og;    r_oc <= n_oc;    r_olast <= n_olast;
    end

    // Memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[n_addr];
    end

    assign o_stall      = r_state != S_IDLE;
    assign o_valid      = r_ov;
    assign o_status     = r_ost;
    assign o_cell_valid = r_ocv;
    assign o_cell_x     = r_ox;
    assign o_cell_y     = r_oy;
    assign o_cell_glyph = r_og;
    assign o_cell_color = r_oc;
    assign o_last       = r_olast;

endmodule

@@ rtl/ccfp_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ccfp_pkg for operand widths.
module ccfp_div
    import ccfp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    logic             r_busy, n_busy;
    logic             r_fin, n_fin;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [DEN_W:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_fin  = r_fin;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        trial  = {r_rem, r_quo[NUM_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_fin  = 1'b0;
            n_cnt  = CNT_W'(NUM_W);
            n_quo  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = DEN_W'(trial - {1'b0, r_den});
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_fin && !r_busy;
    assign o_quo  = r_quo;

endmodule

@@ rtl/ccfp_chk.sv @@
// Port-level checks for the framebuffer plotter, bound to the top level.
// Depends on ccfp_pkg for status codes.
module ccfp_chk
    import ccfp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic        o_cell_valid,
    input logic [5:0]  o_cell_x,
    input logic [7:0]  o_cell_glyph,
    input logic [15:0] o_cell_color,
    input logic        o_last
);

    // A word waiting on a stall stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result word dropped while stalled");

    // An error status ends the command and carries no cell.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_last && !o_cell_valid)
        else $error("error status with cell or without last");

    // A word without a cell has its x, glyph and color fields zero and is the last one.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_cell_valid |-> o_last && o_cell_x == 6'd0
            && o_cell_glyph == 8'd0 && o_cell_color == 16'd0)
        else $error("empty word carries cell data");

    // Cells of one render come strictly left to right.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_cell_valid && !o_last
            |=> !o_valid || !o_cell_valid || o_cell_x > $past(o_cell_x))
        else $error("render cells out of order");

endmodule

bind char_cell_framebuffer_plotter_unit ccfp_chk u_ccfp_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_status     (o_status),
    .o_cell_valid (o_cell_valid),
    .o_cell_x     (o_cell_x),
    .o_cell_glyph (o_cell_glyph),
    .o_cell_color (o_cell_color),
    .o_last       (o_last)
);

@@ bench/tb.sv @@
// Self-checking bench for the character-cell framebuffer plotter unit.
// Needs ccfp_pkg and char_cell_framebuffer_plotter_unit; an internal model predicts each word.
module tb
    import ccfp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB_W       = 64;
    localparam int FB_H       = 64;
    localparam int CELL_COUNT = FB_W * FB_H;
    // Longest quiet stretch: a full-size clear or the sweep after reset.
    localparam int HANG_LIMIT = 100000;

    // One command word as the bench sees it.
    typedef struct {
        logic [2:0]        cmd;
        logic signed [7:0] x1;
        logic signed [7:0] y1;
        logic signed [7:0] x2;
        logic signed [7:0] y2;
        logic [7:0]        glyph;
        logic              ovr;
        logic              udc;
        logic [15:0]       color;
        logic              force_all;
    } t_cmd_word;

    // One result word.
    typedef struct packed {
        logic [1:0]  status;
        logic        cell_valid;
        logic [5:0]  x;
        logic [5:0]  y;
        logic [7:0]  glyph;
        logic [15:0] color;
        logic        last;
    } t_cell_word;

    // A row of the directed table; typed rows carry their expected status by hand.
    typedef struct {
        t_cmd_word  w;
        logic       typed;
        t_cell_word want;
    } t_plan_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_cmd;
    logic signed [7:0] i_x_start, i_y_start, i_x_end, i_y_end;
    logic [7:0]  i_glyph;
    logic        i_overwrite;
    logic        i_use_default_color;
    logic [15:0] i_color;
    logic        i_force_all;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic        o_cell_valid;
    logic [5:0]  o_cell_x, o_cell_y;
    logic [7:0]  o_cell_glyph;
    logic [15:0] o_cell_color;
    logic        o_last;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    char_cell_framebuffer_plotter_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_x_start(i_x_start), .i_y_start(i_y_start),
        .i_x_end(i_x_end), .i_y_end(i_y_end), .i_glyph(i_glyph),
        .i_overwrite(i_overwrite), .i_use_default_color(i_use_default_color),
        .i_color(i_color), .i_force_all(i_force_all),
        .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
        .o_cell_valid(o_cell_valid), .o_cell_x(o_cell_x), .o_cell_y(o_cell_y),
        .o_cell_glyph(o_cell_glyph), .o_cell_color(o_cell_color), .o_last(o_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Bench copy of the framebuffer and its registers.
    logic [7:0]  fb_glyph [CELL_COUNT];
    logic [15:0] fb_color [CELL_COUNT];
    logic        fb_dirty [CELL_COUNT];
    logic [6:0]  width_reg, height_reg;
    logic [7:0]  bg_glyph_reg;
    logic [15:0] bg_color_reg, def_color_reg;

    t_cell_word cells_due[$];
    int         fail_count;
    int         quiet_cycles;
    bit         calm;  // when set, neither side idles

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Size registers saturate: zero acts as one, anything past the store acts as its size.
    function automatic int active_cols();
        return (width_reg == 0) ? 1 : (width_reg > FB_W) ? FB_W : int'(width_reg);
    endfunction

    function automatic int active_rows();
        return (height_reg == 0) ? 1 : (height_reg > FB_H) ? FB_H : int'(height_reg);
    endfunction

    // Plots one cell and returns the status a point command would report.
    function automatic logic [1:0] plot_cell(int x, int y, logic [7:0] g, logic ovr,
                                             logic [15:0] c);
        int a;
        if (x < 0 || y < 0 || x >= active_cols() || y >= active_rows()) return ST_RANGE;
        a = y * FB_W + x;
        if (fb_glyph[a] != bg_glyph_reg && !ovr) return ST_COLLISION;
        fb_glyph[a] = g;
        fb_color[a] = c;
        fb_dirty[a] = 1'b1;
        return ST_OK;
    endfunction

    function automatic t_cell_word status_word(logic [1:0] st);
        t_cell_word r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    // Updates the bench framebuffer for one accepted word and queues its results.
    task automatic apply_command(input t_cmd_word w);
        int x1, y1, x2, y2, dx, dy, t, num, a, emitted;
        logic [15:0] c;
        logic [1:0]  st;
        t_cell_word  r;
        x1 = int'(w.x1);
        y1 = int'(w.y1);
        x2 = int'(w.x2);
        y2 = int'(w.y2);
        c = w.udc ? def_color_reg : w.color;
        case (w.cmd)
            CMD_POINT: begin
                st = plot_cell(x1, y1, w.glyph, w.ovr, c);
                cells_due.push_back(status_word(st));
            end
            CMD_LINE: begin
                if (x1 == x2) begin
                    for (int y = y1; y <= y2; y++) void'(plot_cell(x1, y, w.glyph, w.ovr, c));
                end else if (y1 == y2) begin
                    for (int x = x1; x <= x2; x++) void'(plot_cell(x, y1, w.glyph, w.ovr, c));
                end else begin
                    // Diagonals always walk left to right; the row is rounded half up
                    // from the exact slope, truncating toward zero for negative rows.
                    if (x1 > x2) begin
                        t = x1; x1 = x2; x2 = t;
                        t = y1; y1 = y2; y2 = t;
                    end
                    dx = x2 - x1;
                    dy = y2 - y1;
                    for (int i = 0; i <= dx; i++) begin
                        num = 2 * y1 * dx + 2 * i * dy + dx;
                        void'(plot_cell(x1 + i, num / (2 * dx), w.glyph, w.ovr, c));
                    end
                end
                cells_due.push_back(status_word(ST_OK));
            end
            CMD_CLEAR, CMD_REDRAW: begin
                for (int y = 0; y < active_rows(); y++) begin
                    for (int x = 0; x < active_cols(); x++) begin
                        a = y * FB_W + x;
                        if (w.cmd == CMD_REDRAW) begin
                            fb_dirty[a] = 1'b1;
                        end else if (!w.force_all && fb_glyph[a] == bg_glyph_reg &&
                                     fb_color[a] == bg_color_reg) begin
                            fb_dirty[a] = 1'b0;
                        end else begin
                            fb_glyph[a] = bg_glyph_reg;
                            fb_color[a] = bg_color_reg;
                            fb_dirty[a] = 1'b1;
                        end
                    end
                end
                cells_due.push_back(status_word(ST_OK));
            end
            CMD_RENDER: begin
                if (y1 < 0 || y1 >= active_rows()) begin
                    cells_due.push_back(status_word(ST_RANGE));
                end else begin
                    emitted = 0;
                    for (int x = 0; x < active_cols(); x++) begin
                        a = y1 * FB_W + x;
                        if (fb_dirty[a]) begin
                            r = '0;
                            r.cell_valid = 1'b1;
                            r.x = x[5:0];
                            r.y = y1[5:0];
                            r.glyph = fb_glyph[a];
                            r.color = fb_color[a];
                            cells_due.push_back(r);
                            fb_dirty[a] = 1'b0;
                            emitted++;
                        end
                    end
                    if (emitted == 0) cells_due.push_back(status_word(ST_OK));
                    else cells_due[$].last = 1'b1;
                end
            end
            default: cells_due.push_back(status_word(ST_OK));
        endcase
    endtask

    // Offers one word, waits for it to be taken, then predicts it. A typed row
    // replaces the predicted results with its hand-written expectation.
    task automatic send_word(input t_cmd_word w, input logic typed, input t_cell_word want);
        int mark;
        while (!calm && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cmd <= w.cmd;
        i_x_start <= w.x1;
        i_y_start <= w.y1;
        i_x_end <= w.x2;
        i_y_end <= w.y2;
        i_glyph <= w.glyph;
        i_overwrite <= w.ovr;
        i_use_default_color <= w.udc;
        i_color <= w.color;
        i_force_all <= w.force_all;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        mark = cells_due.size();
        apply_command(w);
        if (typed) begin
            while (cells_due.size() > mark) void'(cells_due.pop_back());
            cells_due.push_back(want);
        end
    endtask

    // Register write followed by a read-back of the masked value.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] masked;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_WIDTH:    begin width_reg = value[6:0];  masked = {25'd0, value[6:0]}; end
            REG_HEIGHT:   begin height_reg = value[6:0]; masked = {25'd0, value[6:0]}; end
            REG_BG_GLYPH: begin bg_glyph_reg = value[7:0]; masked = {24'd0, value[7:0]}; end
            REG_BG_COLOR: begin bg_color_reg = value[15:0]; masked = {16'd0, value[15:0]}; end
            default:      begin def_color_reg = value[15:0]; masked = {16'd0, value[15:0]}; end
        endcase
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== masked) begin
            $display("%0t: register %0d read back expected %h actual %h",
                     $time, idx, masked, prdata);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Coordinate that mostly lands near the active area, sometimes anywhere.
    function automatic logic signed [7:0] pick_coord(int span);
        int v;
        if ($urandom_range(99) < 15) return 8'($urandom_range(255));
        v = int'($urandom_range(span + 1)) - 1;
        return 8'(v);
    endfunction

    function automatic t_cmd_word random_word();
        t_cmd_word w;
        int pick;
        w.glyph = ($urandom_range(99) < 30) ? bg_glyph_reg : 8'($urandom_range(255));
        w.ovr = 1'($urandom_range(1));
        w.udc = 1'($urandom_range(1));
        w.color = 16'($urandom_range(65535));
        w.force_all = 1'($urandom_range(1));
        w.x1 = pick_coord(active_cols());
        w.y1 = pick_coord(active_rows());
        w.x2 = pick_coord(active_cols());
        w.y2 = pick_coord(active_rows());
        pick = $urandom_range(99);
        if (pick < 30) begin
            w.cmd = CMD_POINT;
        end else if (pick < 55) begin
            w.cmd = CMD_LINE;
            // Mostly straight lines, so that collisions and reversed runs come often.
            case ($urandom_range(9))
                0, 1, 2: w.y2 = w.y1;
                3, 4, 5: w.x2 = w.x1;
                default: ;
            endcase
        end else if (pick < 85) begin
            w.cmd = CMD_RENDER;
        end else if (pick < 90) begin
            w.cmd = CMD_CLEAR;
        end else if (pick < 94) begin
            w.cmd = CMD_REDRAW;
        end else begin
            w.cmd = 3'($urandom_range(7, 5));
        end
        return w;
    endfunction

    function automatic t_plan_row row(logic [2:0] cmd, int x1, int y1, int x2, int y2,
                                      int g, logic ovr, logic udc, int c, logic f,
                                      logic typed, logic [1:0] st);
        t_plan_row p;
        p.w.cmd = cmd;
        p.w.x1 = 8'(x1);
        p.w.y1 = 8'(y1);
        p.w.x2 = 8'(x2);
        p.w.y2 = 8'(y2);
        p.w.glyph = 8'(g);
        p.w.ovr = ovr;
        p.w.udc = udc;
        p.w.color = 16'(c);
        p.w.force_all = f;
        p.typed = typed;
        p.want = status_word(st);
        return p;
    endfunction

    // Waits until every queued result has come back.
    task automatic drain();
        while (cells_due.size() != 0) @(posedge i_clk);
    endtask

    // Output stall: random, except while the bench runs its steady stretch.
    always @(posedge i_clk) begin
        i_stall <= calm ? 1'b0 : ($urandom_range(99) < 20);
    end

    // Result checker: every taken word must match the oldest expectation.
    always @(posedge i_clk) begin
        t_cell_word got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_status, o_cell_valid, o_cell_x, o_cell_y, o_cell_glyph,
                   o_cell_color, o_last};
            if (cells_due.size() == 0) begin
                fail_count++;
                if (fail_count < 40)
                    $display("%0t: unexpected word, expected none actual %h", $time, got);
            end else begin
                want = cells_due.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count < 40)
                        $display({"%0t: expected st=%0d v=%0d x=%0d y=%0d g=%h c=%h l=%0d",
                                  " actual st=%0d v=%0d x=%0d y=%0d g=%h c=%h l=%0d"},
                                 $time, want.status, want.cell_valid, want.x, want.y,
                                 want.glyph, want.color, want.last, got.status,
                                 got.cell_valid, got.x, got.y, got.glyph, got.color,
                                 got.last);
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_plan_row   plan[$];
        t_cmd_word   w;
        logic [31:0] sizes [5][2];
        // Inputs known from time zero.
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_cmd <= CMD_POINT;
        i_x_start <= '0;
        i_y_start <= '0;
        i_x_end <= '0;
        i_y_end <= '0;
        i_glyph <= '0;
        i_overwrite <= 1'b0;
        i_use_default_color <= 1'b0;
        i_color <= '0;
        i_force_all <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        fail_count = 0;
        quiet_cycles = 0;
        calm = 1'b0;

        // Bench state after reset: every cell blank and flagged as changed.
        width_reg = RST_WIDTH;
        height_reg = RST_HEIGHT;
        bg_glyph_reg = RST_BG_GLYPH;
        bg_color_reg = RST_BG_COLOR;
        def_color_reg = '0;
        for (int a = 0; a < CELL_COUNT; a++) begin
            fb_glyph[a] = RST_BG_GLYPH;
            fb_color[a] = RST_BG_COLOR;
            fb_dirty[a] = 1'b1;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, run at the reset size of 64 by 64.
        plan.push_back(row(CMD_RENDER, 0, -1, 0, 0, 0, 0, 0, 0, 0, 1, ST_RANGE));
        plan.push_back(row(CMD_RENDER, 0, 64, 0, 0, 0, 0, 0, 0, 0, 1, ST_RANGE));
        plan.push_back(row(CMD_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
        // The row was just flushed, so nothing is left to emit.
        plan.push_back(row(CMD_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK));
        plan.push_back(row(CMD_POINT, -128, 0, 0, 0, 65, 0, 0, 1, 0, 1, ST_RANGE));
        plan.push_back(row(CMD_POINT, 0, 127, 0, 0, 65, 0, 0, 1, 0, 1, ST_RANGE));
        plan.push_back(row(CMD_POINT, 64, 0, 0, 0, 65, 0, 0, 1, 0, 1, ST_RANGE));
        plan.push_back(row(CMD_POINT, 63, 63, 0, 0, 255, 0, 0, 65535, 0, 1, ST_OK));
        plan.push_back(row(CMD_POINT, 63, 63, 0, 0, 1, 0, 0, 7, 0, 1, ST_COLLISION));
        plan.push_back(row(CMD_POINT, 63, 63, 0, 0, 0, 1, 1, 9, 0, 1, ST_OK));
        plan.push_back(row(CMD_LINE, 0, 1, 63, 1, 66, 0, 0, 16'h1234, 0, 0, ST_OK));
        plan.push_back(row(CMD_LINE, 10, 2, 5, 2, 67, 1, 0, 5, 0, 0, ST_OK));
        plan.push_back(row(CMD_LINE, 2, -128, 2, 127, 68, 1, 0, 6, 0, 0, ST_OK));
        plan.push_back(row(CMD_LINE, 3, 40, 3, 30, 69, 1, 0, 6, 0, 0, ST_OK));
        plan.push_back(row(CMD_LINE, -128, 127, 127, -128, 70, 1, 1, 0, 0, 0, ST_OK));
        plan.push_back(row(CMD_LINE, 40, 5, 20, 12, 71, 0, 0, 16'hbeef, 0, 0, ST_OK));
        plan.push_back(row(CMD_LINE, 0, 0, 3, 60, 72, 1, 0, 16'h00ff, 0, 0, ST_OK));
        plan.push_back(row(3'd5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK));
        plan.push_back(row(3'd6, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, ST_OK));
        plan.push_back(row(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK));
        plan.push_back(row(CMD_RENDER, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
        plan.push_back(row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
        plan.push_back(row(CMD_RENDER, 0, 63, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
        plan.push_back(row(CMD_REDRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
        plan.push_back(row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, ST_OK));
        foreach (plan[k]) send_word(plan[k].w, plan[k].typed, plan[k].want);
        i_valid <= 1'b0;
        drain();

        // Random part in five settings: zero and oversized sizes, single rows and
        // columns, and a small random area. The third phase runs without any idling.
        sizes[0] = '{32'd0, 32'd0};
        sizes[1] = '{32'd127, 32'd127};
        sizes[2] = '{32'd64, 32'd1};
        sizes[3] = '{32'd1, 32'd64};
        sizes[4] = '{32'($urandom_range(12, 2)), 32'($urandom_range(12, 2))};
        for (int p = 0; p < 5; p++) begin
            write_reg(REG_WIDTH, sizes[p][0]);
            write_reg(REG_HEIGHT, sizes[p][1]);
            write_reg(REG_BG_GLYPH, (p == 1) ? 32'd255 : (p == 2) ? 32'd0 :
                                    32'($urandom_range(255)));
            write_reg(REG_BG_COLOR, (p == 1) ? 32'hffff : 32'($urandom_range(65535)));
            write_reg(REG_DEF_COLOR, (p == 2) ? 32'hffff : (p == 3) ? 32'd0 :
                                     32'($urandom_range(65535)));
            calm = (p == 2);
            // After a size change, software starts from a forced clear.
            w = '{CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1};
            send_word(w, 1'b0, '0);
            for (int n = 0; n < 100; n++) send_word(random_word(), 1'b0, '0);
            i_valid <= 1'b0;
            drain();
            calm = 1'b0;
        end

        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
